>>> rtl/core/windowed_rms_contact_detector_core_assert.svh
// Assertion macros for the contact detector core.
`ifndef WINDOWED_RMS_CONTACT_DETECTOR_CORE_ASSERT_SVH
`define WINDOWED_RMS_CONTACT_DETECTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WRCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WRCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WRCD_ASSERT(lbl, prop, msg)
`define WRCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/wrcd_pkg.sv
package wrcd_pkg;

  localparam int unsigned WINDOW_DEFAULT = 64;

  localparam logic [15:0] THR_RESET = 16'hFFFF;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_REARM = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;

  localparam logic [1:0] SEL_X   = 2'd0;
  localparam logic [1:0] SEL_Y   = 2'd1;
  localparam logic [1:0] SEL_Z   = 2'd2;
  localparam logic [1:0] SEL_THR = 2'd3;

  localparam logic [3:0] MUL_LAST  = 4'd4;
  localparam logic [3:0] SQRT_LAST = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPDATE,
    ST_CHECK,
    ST_SQRT,
    ST_ROOT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       capture;
    logic [1:0] mul_sel;
    logic       sub_old;
    logic       acc_en;
    logic       thr_load;
    logic       update;
    logic       check;
    logic       sqrt_step;
    logic       rms_load;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic push_go;
    logic full;
    logic triggered;
  } status_t;

endpackage

>>> rtl/core/wrcd_in_if.sv
interface wrcd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport source (output valid, opcode, axis_x, axis_y, axis_z, input ready);
  modport sink (input valid, opcode, axis_x, axis_y, axis_z, output ready);
endinterface

>>> rtl/core/wrcd_out_if.sv
interface wrcd_out_if;
  logic        valid;
  logic        ready;
  logic        is_triggered;
  logic        event_pending;
  logic [15:0] window_rms;
  logic        window_full;

  modport source (output valid, is_triggered, event_pending, window_rms, window_full,
                  input ready);
  modport sink (input valid, is_triggered, event_pending, window_rms, window_full,
                output ready);
endinterface

>>> rtl/core/wrcd_cfg_if.sv
interface wrcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] rms_threshold;

  modport source (output valid, rms_threshold, input ready);
  modport sink (input valid, rms_threshold, output ready);
endinterface

>>> rtl/core/windowed_rms_contact_detector_core.sv
// A push on a full window runs the shared 17x17 multiplier, the window update,
// the threshold check and the 16-step square root before its result loads.
// Pushes before the fill skip the root; other words and ignored pushes skip all.
// The next word is accepted in the cycle after the result register loads.
// Reset is asynchronous, active low: the ring and output fields stay unwritten,
// internal status clears and the threshold returns to 65535.
`include "windowed_rms_contact_detector_core_assert.svh"

module windowed_rms_contact_detector_core #(
  parameter int unsigned WINDOW = wrcd_pkg::WINDOW_DEFAULT
) (
  input logic        clk_i,
  input logic        rst_ni,
  wrcd_in_if.sink    in_chan_i,
  wrcd_out_if.source out_chan_o,
  wrcd_cfg_if.sink   cfg_chan_i
);

  wrcd_pkg::cmd_t    cmd;
  wrcd_pkg::status_t status;

  assign cfg_chan_i.ready = 1'b1;

  wrcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .out_ready_i (out_chan_o.ready),
    .out_valid_o (out_chan_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wrcd_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (in_chan_i.opcode),
    .axis_x_i        (in_chan_i.axis_x),
    .axis_y_i        (in_chan_i.axis_y),
    .axis_z_i        (in_chan_i.axis_z),
    .cfg_valid_i     (cfg_chan_i.valid),
    .cfg_data_i      (cfg_chan_i.rms_threshold),
    .is_triggered_o  (out_chan_o.is_triggered),
    .event_pending_o (out_chan_o.event_pending),
    .window_rms_o    (out_chan_o.window_rms),
    .window_full_o   (out_chan_o.window_full)
  );

  `WRCD_ASSERT(a_trig_src, $rose(status.triggered) |-> $past(cmd.check), "stray trigger")
  `WRCD_ASSERT(a_out_src, $rose(out_chan_o.valid) |-> $past(cmd.load_out), "stray result")
  `WRCD_ASSERT(a_busy, (in_chan_i.valid && in_chan_i.ready) |=> !in_chan_i.ready, "early ready")
  `WRCD_ASSERT_ALWAYS(a_root_excl, !(cmd.sqrt_step && cmd.load_out), "root step during load")

endmodule

>>> rtl/core/wrcd_ctrl.sv
module wrcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  wrcd_pkg::status_t status_i,
  output wrcd_pkg::cmd_t    cmd_o
);

  wrcd_pkg::state_e state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wrcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.push_go ? wrcd_pkg::ST_MUL : wrcd_pkg::ST_OUT;
        end
      end
      wrcd_pkg::ST_MUL: begin
        if (cnt_q == wrcd_pkg::MUL_LAST) state_d = wrcd_pkg::ST_UPDATE;
      end
      wrcd_pkg::ST_UPDATE: state_d = wrcd_pkg::ST_CHECK;
      wrcd_pkg::ST_CHECK: begin
        state_d = status_i.full ? wrcd_pkg::ST_SQRT : wrcd_pkg::ST_OUT;
      end
      wrcd_pkg::ST_SQRT: begin
        if (cnt_q == wrcd_pkg::SQRT_LAST) state_d = wrcd_pkg::ST_ROOT;
      end
      wrcd_pkg::ST_ROOT: state_d = wrcd_pkg::ST_OUT;
      wrcd_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = wrcd_pkg::ST_IDLE;
      end
      default: state_d = wrcd_pkg::ST_IDLE;
    endcase
  end

  assign cnt_d = (state_d != state_q) ? 4'd0 : cnt_q + 4'd1;

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      wrcd_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      wrcd_pkg::ST_MUL: begin
        cmd_o.mul_sel  = cnt_q[1:0];
        cmd_o.sub_old  = (cnt_q == 4'd0);
        cmd_o.acc_en   = (cnt_q != 4'd0) && (cnt_q != wrcd_pkg::MUL_LAST);
        cmd_o.thr_load = (cnt_q == wrcd_pkg::MUL_LAST);
      end
      wrcd_pkg::ST_UPDATE: cmd_o.update = 1'b1;
      wrcd_pkg::ST_CHECK: cmd_o.check = 1'b1;
      wrcd_pkg::ST_SQRT: cmd_o.sqrt_step = 1'b1;
      wrcd_pkg::ST_ROOT: cmd_o.rms_load = 1'b1;
      wrcd_pkg::ST_OUT: cmd_o.load_out = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrcd_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/wrcd_datapath.sv
module wrcd_datapath #(
  parameter int unsigned WINDOW = wrcd_pkg::WINDOW_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wrcd_pkg::cmd_t     cmd_i,
  output wrcd_pkg::status_t  status_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic               cfg_valid_i,
  input  logic [15:0]        cfg_data_i,
  output logic               is_triggered_o,
  output logic               event_pending_o,
  output logic [15:0]        window_rms_o,
  output logic               window_full_o
);

  localparam int unsigned LOG2W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = LOG2W + 1;
  localparam int unsigned SUM_W  = 32 + LOG2W;

  logic [15:0]        thr_q;
  logic [1:0]         op_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [16:0] mul_a;
  logic signed [33:0] mul_p;
  logic [31:0]        prod_q, sq_q, thr2_q, rd_q;
  logic [31:0]        mem_q [WINDOW];
  logic [LOG2W-1:0]   wp_q;
  logic [FILL_W-1:0]  fill_q;
  logic [SUM_W-1:0]   sum_q;
  logic               trig_q, ev_q;
  logic [15:0]        rms_q;
  logic [31:0]        rad_q;
  logic [16:0]        rem_q;
  logic [15:0]        root_q;
  logic [19:0]        trial;
  logic               full;

  assign full = (fill_q == FILL_W'(WINDOW));

  assign status_o.push_go   = (opcode_i == wrcd_pkg::OP_PUSH) && !trig_q;
  assign status_o.full      = full;
  assign status_o.triggered = trig_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      wrcd_pkg::SEL_X:   mul_a = {ax_q[15], ax_q};
      wrcd_pkg::SEL_Y:   mul_a = {ay_q[15], ay_q};
      wrcd_pkg::SEL_Z:   mul_a = {az_q[15], az_q};
      wrcd_pkg::SEL_THR: mul_a = {1'b0, thr_q};
      default:           mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_a;

  assign trial = {1'b0, rem_q, rad_q[31:30]} - {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      ax_q <= axis_x_i;
      ay_q <= axis_y_i;
      az_q <= axis_z_i;
      sq_q <= '0;
    end else if (cmd_i.acc_en) begin
      sq_q <= sq_q + prod_q;
    end
    prod_q <= mul_p[31:0];
    if (cmd_i.thr_load) thr2_q <= prod_q;
    if (cmd_i.update) mem_q[wp_q] <= sq_q;
    rd_q <= mem_q[wp_q];
    if (cmd_i.check) begin
      rad_q  <= sum_q[SUM_W-1 -: 32];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[29:0], 2'b00};
      if (!trial[19]) begin
        rem_q  <= trial[16:0];
        root_q <= {root_q[14:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[14:0], rad_q[31:30]};
        root_q <= {root_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= wrcd_pkg::THR_RESET;
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      trig_q <= 1'b0;
      ev_q   <= 1'b0;
      rms_q  <= '0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if (cmd_i.sub_old && full) begin
        sum_q <= sum_q - {{LOG2W{1'b0}}, rd_q};
      end
      if (cmd_i.update) begin
        sum_q <= sum_q + {{LOG2W{1'b0}}, sq_q};
        wp_q  <= wp_q + LOG2W'(1);
        if (!full) fill_q <= fill_q + FILL_W'(1);
      end
      if (cmd_i.check && full) begin
        if (sum_q > {thr2_q, {LOG2W{1'b0}}}) begin
          trig_q <= 1'b1;
          ev_q   <= 1'b1;
        end
      end
      if (cmd_i.rms_load) rms_q <= root_q;
      if (cmd_i.load_out) begin
        if (op_q == wrcd_pkg::OP_REARM) begin
          wp_q   <= '0;
          fill_q <= '0;
          sum_q  <= '0;
          trig_q <= 1'b0;
          ev_q   <= 1'b0;
          rms_q  <= '0;
        end else if (op_q == wrcd_pkg::OP_POLL) begin
          ev_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (op_q == wrcd_pkg::OP_REARM) begin
        is_triggered_o  <= 1'b0;
        event_pending_o <= 1'b0;
        window_rms_o    <= '0;
        window_full_o   <= 1'b0;
      end else begin
        is_triggered_o  <= trig_q;
        event_pending_o <= ev_q;
        window_rms_o    <= rms_q;
        window_full_o   <= full;
      end
    end
  end

endmodule

>>> verif/windowed_rms_contact_detector_core_tb.sv
`timescale 1ns / 100ps

module windowed_rms_contact_detector_core_tb;
  import wrcd_pkg::OP_PUSH;
  import wrcd_pkg::OP_REARM;
  import wrcd_pkg::OP_POLL;
  import wrcd_pkg::WINDOW_DEFAULT;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned WIN          = WINDOW_DEFAULT;
  localparam int unsigned PTR_W        = $clog2(WIN);
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic        trig;
    logic        evt;
    logic [15:0] rms;
    logic        full;
  } det_result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               typed;
    det_result_t        res;
  } dir_row_t;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_PATTERN,
    SINK_MOSTLY
  } sink_mode_e;

  localparam det_result_t RES_CLEAR = '0;

  localparam dir_row_t DIRECTED [16] = '{
    '{OP_POLL,   16'h0000, 16'h0000, 16'h0000, 1'b1, RES_CLEAR},
    '{OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b1, RES_CLEAR},
    '{OP_PUSH,   16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, RES_CLEAR},
    '{OP_PUSH,   16'h8000, 16'h8000, 16'h8000, 1'b0, RES_CLEAR},
    '{OP_PUSH,   16'h0000, 16'h0000, 16'h0000, 1'b0, RES_CLEAR},
    '{OP_PUSH,   16'hFFFF, 16'h0001, 16'h8000, 1'b0, RES_CLEAR},
    '{OP_PUSH,   16'h5555, 16'hAAAA, 16'h7FFF, 1'b0, RES_CLEAR},
    '{OP_PUSH,   16'hAAAA, 16'h5555, 16'h0000, 1'b0, RES_CLEAR},
    '{OP_POLL,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, RES_CLEAR},
    '{OP_UNUSED, 16'h8000, 16'h7FFF, 16'h5555, 1'b1, RES_CLEAR},
    '{OP_REARM,  16'h7FFF, 16'h8000, 16'hAAAA, 1'b1, RES_CLEAR},
    '{OP_PUSH,   16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, RES_CLEAR},
    '{OP_POLL,   16'h0000, 16'h0000, 16'h0000, 1'b1, RES_CLEAR},
    '{OP_REARM,  16'h0000, 16'h0000, 16'h0000, 1'b1, RES_CLEAR},
    '{OP_PUSH,   16'h0001, 16'hFFFF, 16'h0001, 1'b0, RES_CLEAR},
    '{OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b1, RES_CLEAR}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wrcd_in_if  in_chan ();
  wrcd_out_if out_chan ();
  wrcd_cfg_if cfg_chan ();

  windowed_rms_contact_detector_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0]      sq_ring [WIN];
  logic [PTR_W-1:0] ring_wr;
  logic [PTR_W:0]   ring_fill;
  logic [37:0]      sq_total;
  logic             trig_q;
  logic             evt_q;
  logic [15:0]      rms_q;
  logic [15:0]      thr_q;

  det_result_t status_q [$];

  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned words_sent;
  int unsigned ignored_pushes;
  int unsigned live_items;
  int unsigned window_fills;
  int unsigned trigger_count;
  int unsigned event_polls;
  int unsigned threshold_writes;
  int unsigned hold_requests;
  int unsigned burst_left;
  int unsigned cycle_count;
  bit          gaps_on;

  function automatic logic [15:0] floor_sqrt(input logic [31:0] v);
    logic [15:0] root;
    logic [15:0] cand;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (16'd1 << b);
      if (33'(cand) * 33'(cand) <= 33'(v)) root = cand;
    end
    return root;
  endfunction

  function automatic void clear_detector();
    ring_wr   = '0;
    ring_fill = '0;
    sq_total  = '0;
    trig_q    = 1'b0;
    evt_q     = 1'b0;
    rms_q     = '0;
  endfunction

  function automatic det_result_t predict_status(input logic [1:0] op,
                                                 input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic signed [15:0] z);
    int          sx;
    int          sy;
    int          sz;
    logic [31:0] sq;
    logic        reported;
    det_result_t res;
    sx = x;
    sy = y;
    sz = z;
    case (op)
      OP_PUSH: begin
        if (!trig_q) begin
          sq = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
          if (ring_fill == WIN) begin
            sq_total -= sq_ring[ring_wr];
          end else begin
            ring_fill++;
            if (ring_fill == WIN) window_fills++;
          end
          sq_ring[ring_wr] = sq;
          sq_total += sq;
          ring_wr++;
          if (ring_fill == WIN) begin
            rms_q = floor_sqrt(32'(sq_total / WIN));
            if (64'(sq_total) > 64'(thr_q) * 64'(thr_q) * 64'(WIN)) begin
              trig_q = 1'b1;
              evt_q  = 1'b1;
              trigger_count++;
            end
          end
        end
        reported = evt_q;
      end
      OP_REARM: begin
        clear_detector();
        reported = evt_q;
      end
      OP_POLL: begin
        reported = evt_q;
        if (evt_q) event_polls++;
        evt_q = 1'b0;
      end
      default: begin
        reported = evt_q;
      end
    endcase
    res.trig = trig_q;
    res.evt  = reported;
    res.rms  = rms_q;
    res.full = (ring_fill == WIN);
    return res;
  endfunction

  function automatic logic signed [15:0] rand_axis(input int unsigned amp);
    int v;
    if (amp >= 32768) return 16'($urandom);
    v = int'($urandom_range(0, 2 * amp)) - int'(amp);
    return 16'(v);
  endfunction

  task automatic offer_word(input logic [1:0] op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z,
                            input logic typed, input det_result_t typed_res);
    int unsigned gap;
    det_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.axis_x <= x;
    in_chan.axis_y <= y;
    in_chan.axis_z <= z;
    do @(posedge clk_i); while (!in_chan.ready);
    words_sent++;
    if (op == OP_PUSH && trig_q) ignored_pushes++;
    else live_items++;
    want = predict_status(op, x, y, z);
    status_q.push_back(typed ? typed_res : want);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] level);
    cfg_chan.valid         <= 1'b1;
    cfg_chan.rms_threshold <= level;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    thr_q = level;
    threshold_writes++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    det_result_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (status_q.size() == 0) begin
        $error("Result word arrived with nothing expected.");
        fail_count++;
      end else begin
        want = status_q.pop_front();
        compare_field("is_triggered", 16'(want.trig), 16'(out_chan.is_triggered));
        compare_field("event_pending", 16'(want.evt), 16'(out_chan.event_pending));
        compare_field("window_rms", want.rms, out_chan.window_rms);
        compare_field("window_full", 16'(want.full), 16'(out_chan.window_full));
        results_checked++;
      end
    end
  end

  initial begin : result_sink
    int unsigned mode_cycles;
    int unsigned holds_served;
    sink_mode_e  sink_mode;
    mode_cycles  = 0;
    holds_served = 0;
    sink_mode    = SINK_OPEN;
    forever begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        case (sink_mode)
          SINK_OPEN:    out_chan.ready <= 1'b1;
          SINK_COIN:    out_chan.ready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: out_chan.ready <= (mode_cycles % 5) < 2;
          default:      out_chan.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
        mode_cycles++;
        if (mode_cycles == 48) begin
          mode_cycles = 0;
          sink_mode = sink_mode_e'($urandom_range(0, 3));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned run_idx;
    int unsigned amp;
    int unsigned thr;
    int unsigned n_push;
    int unsigned pushes_done;
    int unsigned pick;
    bit          boundary;
    logic signed [15:0] bx;

    fail_count       = 0;
    results_checked  = 0;
    words_sent       = 0;
    ignored_pushes   = 0;
    live_items       = 0;
    window_fills     = 0;
    trigger_count    = 0;
    event_polls      = 0;
    threshold_writes = 0;
    hold_requests    = 0;
    burst_left       = 0;
    cycle_count      = 0;
    gaps_on          = 1'b1;
    thr_q            = 16'hFFFF;
    clear_detector();

    in_chan.valid          <= 1'b0;
    in_chan.opcode         <= OP_PUSH;
    in_chan.axis_x         <= '0;
    in_chan.axis_y         <= '0;
    in_chan.axis_z         <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.rms_threshold <= '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      offer_word(DIRECTED[r].op, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z,
                 DIRECTED[r].typed, DIRECTED[r].res);
    end

    live_items = 0;
    run_idx    = 0;
    while (live_items < RANDOM_ITEMS) begin
      drain_results();
      boundary = 1'b0;
      if (run_idx == 0) begin
        amp = $urandom_range(1, 32767);
        thr = 0;
      end else if (run_idx == 1) begin
        amp = 32768;
        thr = 65535;
      end else if (run_idx % 4 == 3) begin
        boundary = 1'b1;
        amp = $urandom_range(1, 32766);
        thr = amp;
      end else begin
        amp = $urandom_range(1, 32767);
        thr = (amp * $urandom_range(85, 115)) / 100;
        if (thr > 65535) thr = 65535;
      end
      write_threshold(16'(thr));
      if (run_idx == 2) hold_requests++;
      gaps_on = (run_idx != 1);

      offer_word(OP_REARM, rand_axis(32768), rand_axis(32768), rand_axis(32768),
                 1'b0, RES_CLEAR);
      n_push = WIN + $urandom_range(8, 40);
      pushes_done = 0;
      while (pushes_done < n_push) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          offer_word(OP_POLL, rand_axis(32768), rand_axis(32768), rand_axis(32768),
                     1'b0, RES_CLEAR);
        end else if (pick < 11) begin
          offer_word(OP_UNUSED, rand_axis(32768), rand_axis(32768), rand_axis(32768),
                     1'b0, RES_CLEAR);
        end else if (pick < 12) begin
          offer_word(OP_REARM, rand_axis(32768), rand_axis(32768), rand_axis(32768),
                     1'b0, RES_CLEAR);
        end else if (boundary) begin
          bx = 16'(amp);
          if (ring_fill == WIN && $urandom_range(0, 5) == 0) bx = 16'(amp + 1);
          if ($urandom_range(0, 1) != 0) bx = -bx;
          offer_word(OP_PUSH, bx, '0, '0, 1'b0, RES_CLEAR);
          pushes_done++;
        end else begin
          offer_word(OP_PUSH, rand_axis(amp), rand_axis(amp), rand_axis(amp),
                     1'b0, RES_CLEAR);
          pushes_done++;
        end
      end
      offer_word(OP_POLL, '0, '0, '0, 1'b0, RES_CLEAR);
      offer_word(OP_POLL, '0, '0, '0, 1'b0, RES_CLEAR);
      run_idx++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (status_q.size() != 0) begin
      $error("%0d expected results never arrived.", status_q.size());
      fail_count++;
    end

    $display("Sent %0d words over %0d threshold settings, %0d pushes ignored while latched.",
             words_sent, threshold_writes, ignored_pushes);
    $display("Checked %0d results: %0d window fills, %0d triggers, %0d polled events.",
             results_checked, window_fills, trigger_count, event_polls);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> windowed_rms_contact_detector_core.f
+incdir+rtl/core
rtl/core/wrcd_pkg.sv
rtl/core/wrcd_in_if.sv
rtl/core/wrcd_out_if.sv
rtl/core/wrcd_cfg_if.sv
rtl/core/wrcd_ctrl.sv
rtl/core/wrcd_datapath.sv
rtl/core/windowed_rms_contact_detector_core.sv
verif/windowed_rms_contact_detector_core_tb.sv
